>>> rtl/pcrc_pkg.sv
// ----------------------------------------------------------------------------
// pcrc_pkg
// shared constants and types of the programmable crc generator / checker
// ----------------------------------------------------------------------------
package pcrc_pkg;

   // default for the largest supported crc width
   localparam int MAX_CRC_WIDTH_DEF = 32;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // widths fixed by the register map
   localparam int POLY_W  = 32;
   localparam int LEN_W   = 6;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GEN_POLY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GEN_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE    = 2'd2;

   // register reset values
   localparam logic [POLY_W-1:0] GEN_POLY_RST   = 32'h0000_1021;
   localparam logic [LEN_W-1:0]  GEN_LENGTH_RST = 6'd17;

   // operating modes
   localparam logic MODE_GENERATE = 1'b0;
   localparam logic MODE_CHECK    = 1'b1;

   // what a queued entry expands into
   typedef enum logic [1:0] {
      KIND_ECHO    = 2'd0,   // echoed bit, frame continues
      KIND_GEN_END = 2'd1,   // echoed bit followed by the remainder bits
      KIND_CHECK   = 2'd2    // single pass/fail result
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     data_bit;
      logic     frame_ok;
   } pcrc_ctl_type;

endpackage

>>> rtl/programmable_crc_gen_check.sv
// ----------------------------------------------------------------------------
// programmable_crc_gen_check
// bit-serial crc generator and checker with a programmable generator
// ----------------------------------------------------------------------------
// One frame bit is taken per clock while req_full is low; the remainder update
// is a single masked shift-xor in the front part, so input never waits on the
// division itself. Results leave through a one-entry output register at one
// per clock while rsp_pop is high. In generate mode every bit gives one
// result, and the last bit gives 1 + W results (W = gen_length - 1, clamped
// to 1..MAX_CRC_WIDTH), so a frame end gives W extra results; a four-entry
// queue between front and back absorbs that, and req_full rises only when the
// queue is full because the result side is slower or stalled. In check mode
// only the frame's last bit gives a result. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module programmable_crc_gen_check #(
   parameter int MAX_CRC_WIDTH = pcrc_pkg::MAX_CRC_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // bit input
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_data_bit,
   input  logic                              req_frame_end,
   // results
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic                              rsp_out_bit,
   output logic                              rsp_is_check_bit,
   output logic                              rsp_frame_ok,
   output logic                              rsp_run_last,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pcrc_pkg::POLY_W-1:0]       csr_wdata
);

   localparam int WW = $clog2(MAX_CRC_WIDTH + 1);

   // configuration registers
   logic [pcrc_pkg::POLY_W-1:0] gen_poly_ff, gen_poly_in;
   logic [pcrc_pkg::LEN_W-1:0]  gen_length_ff, gen_length_in;
   logic                        op_mode_ff, op_mode_in;

   // front to queue
   logic                        accept;
   logic                        f_push;
   pcrc_pkg::pcrc_ctl_type      f_ctl;
   logic [MAX_CRC_WIDTH-1:0]    f_rem;
   logic [WW-1:0]               f_width;

   // queue to back
   pcrc_pkg::pcrc_ctl_type      b_ctl;
   logic [MAX_CRC_WIDTH-1:0]    b_rem;
   logic [WW-1:0]               b_width;
   logic                        q_empty;
   logic                        q_pop;
   logic                        q_full;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      gen_poly_in   = gen_poly_ff;
      gen_length_in = gen_length_ff;
      op_mode_in    = op_mode_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pcrc_pkg::CSR_GEN_POLY:   gen_poly_in   = csr_wdata;
            pcrc_pkg::CSR_GEN_LENGTH: gen_length_in = csr_wdata[pcrc_pkg::LEN_W-1:0];
            pcrc_pkg::CSR_OP_MODE:    op_mode_in    = csr_wdata[0];
            default: begin
               // unmapped index, write is dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_poly_ff   <= pcrc_pkg::GEN_POLY_RST;
         gen_length_ff <= pcrc_pkg::GEN_LENGTH_RST;
         op_mode_ff    <= pcrc_pkg::MODE_GENERATE;
      end else begin
         gen_poly_ff   <= gen_poly_in;
         gen_length_ff <= gen_length_in;
         op_mode_ff    <= op_mode_in;
      end
   end

   // input transfer
   assign req_full = q_full;
   assign accept   = req_push && !req_full;

   // front: remainder update and classification
   pcrc_front #(
      .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_bit   (req_data_bit),
      .frame_end  (req_frame_end),
      .gen_poly   (gen_poly_ff),
      .gen_length (gen_length_ff),
      .op_mode    (op_mode_ff),
      .q_push     (f_push),
      .q_ctl      (f_ctl),
      .q_rem      (f_rem),
      .q_width    (f_width)
   );

   // decoupling queue, also carries the remainder snapshot of a frame end
   pcrc_queue #(
      .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (f_push),
      .wr_ctl   (f_ctl),
      .wr_rem   (f_rem),
      .wr_width (f_width),
      .rd_en    (q_pop),
      .rd_ctl   (b_ctl),
      .rd_rem   (b_rem),
      .rd_width (b_width),
      .full     (q_full),
      .empty    (q_empty)
   );

   // back: serializes results into the output register
   pcrc_back #(
      .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_ctl            (b_ctl),
      .q_rem            (b_rem),
      .q_width          (b_width),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_out_bit      (rsp_out_bit),
      .rsp_is_check_bit (rsp_is_check_bit),
      .rsp_frame_ok     (rsp_frame_ok),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

>>> rtl/pcrc_front.sv
// ----------------------------------------------------------------------------
// pcrc_front
// remainder register, one shift-xor step per accepted bit, entry classification
// ----------------------------------------------------------------------------
module pcrc_front #(
   parameter int MAX_CRC_WIDTH = pcrc_pkg::MAX_CRC_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic                                   data_bit,
   input  logic                                   frame_end,
   input  logic [pcrc_pkg::POLY_W-1:0]            gen_poly,
   input  logic [pcrc_pkg::LEN_W-1:0]             gen_length,
   input  logic                                   op_mode,
   output logic                                   q_push,
   output pcrc_pkg::pcrc_ctl_type                 q_ctl,
   output logic [MAX_CRC_WIDTH-1:0]               q_rem,
   output logic [$clog2(MAX_CRC_WIDTH+1)-1:0]     q_width
);

   localparam int WW = $clog2(MAX_CRC_WIDTH + 1);
   localparam int IW = (MAX_CRC_WIDTH > 1) ? $clog2(MAX_CRC_WIDTH) : 1;
   localparam int PW = (MAX_CRC_WIDTH > pcrc_pkg::POLY_W) ? MAX_CRC_WIDTH : pcrc_pkg::POLY_W;
   localparam logic [6:0] LEN_TOP = 7'(MAX_CRC_WIDTH + 1);

   logic [MAX_CRC_WIDTH-1:0] rem_ff, rem_in;
   logic [MAX_CRC_WIDTH-1:0] mask;
   logic [MAX_CRC_WIDTH-1:0] poly_m;
   logic [MAX_CRC_WIDTH-1:0] rem_next;
   logic [PW-1:0]            poly_ext;
   logic [6:0]               len_ext;
   logic [6:0]               width_full;
   logic [WW-1:0]            width;
   logic [IW-1:0]            msb_idx;
   logic                     fb;

   // effective crc width, length clamped to the supported range
   always_comb begin
      len_ext = 7'(gen_length);
      if (len_ext < 7'd2) begin
         width_full = 7'd1;
      end else if (len_ext > LEN_TOP) begin
         width_full = LEN_TOP - 7'd1;
      end else begin
         width_full = len_ext - 7'd1;
      end
      width   = width_full[WW-1:0];
      msb_idx = IW'(width_full - 7'd1);
   end

   always_comb begin
      for (int i = 0; i < MAX_CRC_WIDTH; i++) begin
         mask[i] = (7'(i) < width_full);
      end
   end

   assign poly_ext = PW'(gen_poly);
   assign poly_m   = poly_ext[MAX_CRC_WIDTH-1:0] & mask;

   // shift-register form of the division step
   assign fb       = rem_ff[msb_idx] ^ data_bit;
   assign rem_next = ((rem_ff << 1) & mask) ^ (fb ? poly_m : '0);

   always_comb begin
      rem_in = rem_ff;
      if (accept) begin
         rem_in = frame_end ? '0 : rem_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   // classify the bit into a queue entry
   always_comb begin
      q_ctl.data_bit = data_bit;
      q_ctl.frame_ok = (rem_next == '0);
      q_rem          = rem_next;
      q_width        = width;
      if (op_mode == pcrc_pkg::MODE_CHECK) begin
         q_ctl.kind = pcrc_pkg::KIND_CHECK;
         q_push     = accept && frame_end;
      end else begin
         q_ctl.kind = frame_end ? pcrc_pkg::KIND_GEN_END : pcrc_pkg::KIND_ECHO;
         q_push     = accept;
      end
   end

endmodule

>>> rtl/pcrc_queue.sv
// ----------------------------------------------------------------------------
// pcrc_queue
// short fifo of classified entries between front and back
// ----------------------------------------------------------------------------
module pcrc_queue #(
   parameter int MAX_CRC_WIDTH = pcrc_pkg::MAX_CRC_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  pcrc_pkg::pcrc_ctl_type                 wr_ctl,
   input  logic [MAX_CRC_WIDTH-1:0]               wr_rem,
   input  logic [$clog2(MAX_CRC_WIDTH+1)-1:0]     wr_width,
   input  logic                                   rd_en,
   output pcrc_pkg::pcrc_ctl_type                 rd_ctl,
   output logic [MAX_CRC_WIDTH-1:0]               rd_rem,
   output logic [$clog2(MAX_CRC_WIDTH+1)-1:0]     rd_width,
   output logic                                   full,
   output logic                                   empty
);

   localparam int WW    = $clog2(MAX_CRC_WIDTH + 1);
   localparam int DEPTH = pcrc_pkg::QUEUE_DEPTH;
   localparam int AW    = $clog2(DEPTH);

   pcrc_pkg::pcrc_ctl_type   ctl_ff   [DEPTH];
   logic [MAX_CRC_WIDTH-1:0] rem_ff   [DEPTH];
   logic [WW-1:0]            width_ff [DEPTH];
   logic [AW-1:0]            wptr_ff, wptr_in;
   logic [AW-1:0]            rptr_ff, rptr_in;
   logic [AW:0]              count_ff, count_in;
   logic                     do_wr, do_rd;

   assign full  = (count_ff == (AW+1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;

   always_comb begin
      wptr_in  = do_wr ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_rd ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         ctl_ff[wptr_ff]   <= wr_ctl;
         rem_ff[wptr_ff]   <= wr_rem;
         width_ff[wptr_ff] <= wr_width;
      end
   end

   assign rd_ctl   = ctl_ff[rptr_ff];
   assign rd_rem   = rem_ff[rptr_ff];
   assign rd_width = width_ff[rptr_ff];

endmodule

>>> rtl/pcrc_back.sv
// ----------------------------------------------------------------------------
// pcrc_back
// expands queued entries into results and holds the result register
// ----------------------------------------------------------------------------
module pcrc_back #(
   parameter int MAX_CRC_WIDTH = pcrc_pkg::MAX_CRC_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pcrc_pkg::pcrc_ctl_type                 q_ctl,
   input  logic [MAX_CRC_WIDTH-1:0]               q_rem,
   input  logic [$clog2(MAX_CRC_WIDTH+1)-1:0]     q_width,
   input  logic                                   q_empty,
   output logic                                   q_pop,
   input  logic                                   rsp_pop,
   output logic                                   rsp_empty,
   output logic                                   rsp_out_bit,
   output logic                                   rsp_is_check_bit,
   output logic                                   rsp_frame_ok,
   output logic                                   rsp_run_last
);

   localparam int WW = $clog2(MAX_CRC_WIDTH + 1);
   localparam int IW = (MAX_CRC_WIDTH > 1) ? $clog2(MAX_CRC_WIDTH) : 1;

   logic [MAX_CRC_WIDTH-1:0] sh_ff, sh_in;
   logic [WW-1:0]            cnt_ff, cnt_in;
   logic                     valid_ff, valid_in;
   logic                     bit_ff, bit_in;
   logic                     chk_ff, chk_in;
   logic                     ok_ff, ok_in;
   logic                     last_ff, last_in;
   logic                     load;
   logic [IW-1:0]            bit_idx;

   assign load    = !valid_ff || rsp_pop;
   assign bit_idx = IW'(cnt_ff - 1'b1);

   always_comb begin
      sh_in    = sh_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      bit_in   = bit_ff;
      chk_in   = chk_ff;
      ok_in    = ok_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      if (load) begin
         if (cnt_ff != '0) begin
            // remainder bits, most significant first
            valid_in = 1'b1;
            bit_in   = sh_ff[bit_idx];
            chk_in   = 1'b1;
            ok_in    = 1'b0;
            last_in  = (cnt_ff == WW'(1));
            cnt_in   = cnt_ff - 1'b1;
         end else if (!q_empty) begin
            q_pop    = 1'b1;
            valid_in = 1'b1;
            case (q_ctl.kind)
               pcrc_pkg::KIND_ECHO: begin
                  bit_in  = q_ctl.data_bit;
                  chk_in  = 1'b0;
                  ok_in   = 1'b0;
                  last_in = 1'b1;
               end
               pcrc_pkg::KIND_GEN_END: begin
                  bit_in  = q_ctl.data_bit;
                  chk_in  = 1'b0;
                  ok_in   = 1'b0;
                  last_in = 1'b0;
                  sh_in   = q_rem;
                  cnt_in  = q_width;
               end
               pcrc_pkg::KIND_CHECK: begin
                  bit_in  = 1'b0;
                  chk_in  = 1'b0;
                  ok_in   = q_ctl.frame_ok;
                  last_in = 1'b1;
               end
               default: begin
                  valid_in = 1'b0;
               end
            endcase
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff   <= sh_in;
      bit_ff  <= bit_in;
      chk_ff  <= chk_in;
      ok_ff   <= ok_in;
      last_ff <= last_in;
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_out_bit      = bit_ff;
   assign rsp_is_check_bit = chk_ff;
   assign rsp_frame_ok     = ok_ff;
   assign rsp_run_last     = last_ff;

endmodule

>>> rtl/pcrc_checker.sv
// ----------------------------------------------------------------------------
// pcrc_checker
// port-level checks of the programmable crc generator / checker
// ----------------------------------------------------------------------------
module pcrc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_empty,
   input logic rsp_pop,
   input logic rsp_out_bit,
   input logic rsp_is_check_bit,
   input logic rsp_frame_ok,
   input logic rsp_run_last
);

   // a waiting result holds until its transfer
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_bit) &&
         $stable(rsp_is_check_bit) && $stable(rsp_frame_ok) && $stable(rsp_run_last)))
      else $error("result changed while stalled");

   // check bits never carry a frame verdict
   a_chk_no_ok : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_check_bit) |-> !rsp_frame_ok)
      else $error("check bit with frame_ok set");

   // a passing verdict is a lone final result with a zero bit
   a_ok_shape : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_ok) |-> (rsp_run_last && !rsp_out_bit))
      else $error("malformed frame verdict");

   // remainder bits follow each other without a gap
   a_chk_run : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_is_check_bit && !rsp_run_last) |=>
         (!rsp_empty && rsp_is_check_bit))
      else $error("remainder run broken");

   // nothing waits right after reset
   a_reset_empty : assert property (@(posedge clock)
      ($past(reset) && !reset) |-> rsp_empty)
      else $error("result present after reset");

endmodule

bind programmable_crc_gen_check pcrc_checker u_pcrc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_out_bit      (rsp_out_bit),
   .rsp_is_check_bit (rsp_is_check_bit),
   .rsp_frame_ok     (rsp_frame_ok),
   .rsp_run_last     (rsp_run_last)
);
